// File: src/lsrs_pkg.sv
// Shared types and constants for the link setup request serialiser.
`timescale 1ns / 1ps
package lsrs_pkg;

  localparam int unsigned QueueDepthDefault    = 16;
  localparam int unsigned IncomingSlotsDefault = 8;
  localparam int unsigned AddrW                = 48;
  localparam int unsigned ApbAddrW             = 3;

  typedef enum logic [2:0] {
    OP_ENQ_CONN    = 3'd0,
    OP_REG_IN      = 3'd1,
    OP_CONN_DONE   = 3'd2,
    OP_CONN_FAIL   = 3'd3,
    OP_CANCEL_CONN = 3'd4,
    OP_ENQ_NAME    = 3'd5,
    OP_NAME_DONE   = 3'd6,
    OP_CANCEL_NAME = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    RES_ACCEPTED      = 4'd0,
    RES_LAUNCH_CONN   = 4'd1,
    RES_LAUNCH_NAME   = 4'd2,
    RES_DONE_OUT      = 4'd3,
    RES_DONE_IN       = 4'd4,
    RES_DONE_UNKNOWN  = 4'd5,
    RES_CANCEL_FL_CON = 4'd6,
    RES_CANCEL_Q_CON  = 4'd7,
    RES_CANCEL_FL_NAM = 4'd8,
    RES_CANCEL_Q_NAM  = 4'd9,
    RES_NOT_FOUND     = 4'd10,
    RES_NONE_OUT      = 4'd11,
    RES_FAIL_NAME     = 4'd12,
    RES_NAME_IN_CONN  = 4'd13,
    RES_QUEUE_FULL    = 4'd14,
    RES_SET_FULL      = 4'd15
  } res_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SH_RD,
    S_SH_WR,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_EMIT1,
    S_EMIT2
  } state_e;

  localparam logic KindConn = 1'b0;
  localparam logic KindName = 1'b1;

  typedef struct packed {
    logic [2:0]       op;
    logic [AddrW-1:0] peer_address;
  } in_word_t;

  typedef struct packed {
    logic [3:0]       event_res;
    logic [AddrW-1:0] event_address;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] addr;
  } q_entry_t;

  typedef struct packed {
    logic             reg_en;
    logic             clr_en;
    logic [AddrW-1:0] addr;
  } inset_cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic empty;
  } inset_stat_t;

endpackage

// File: src/lsrs_qmem.sv
// Wait queue storage: one write port, one registered read port.
`timescale 1ns / 1ps
module lsrs_qmem import lsrs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  localparam int unsigned IW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  q_entry_t      wdata_i,
  input  logic [IW-1:0] raddr_i,
  output q_entry_t      rdata_o
);

  q_entry_t mem_q [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/lsrs_inset.sv
// Set of pending incoming peer addresses with parallel lookup.
`timescale 1ns / 1ps
module lsrs_inset import lsrs_pkg::*; #(
  parameter int unsigned INCOMING_SLOTS = IncomingSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  inset_cmd_t  cmd_i,
  output inset_stat_t stat_o
);

  logic [INCOMING_SLOTS-1:0] valid_q, valid_d;
  logic [AddrW-1:0]          addr_q [INCOMING_SLOTS];
  logic [INCOMING_SLOTS-1:0] match;
  logic [INCOMING_SLOTS-1:0] take;

  always_comb begin
    logic found;
    found = 1'b0;
    for (int i = 0; i < INCOMING_SLOTS; i++) begin
      match[i] = valid_q[i] && (addr_q[i] == cmd_i.addr);
      take[i]  = !valid_q[i] && !found;
      if (!valid_q[i]) found = 1'b1;
    end
  end

  assign stat_o.hit   = |match;
  assign stat_o.full  = &valid_q;
  assign stat_o.empty = ~|valid_q;

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.reg_en && !stat_o.hit) begin
      valid_d = valid_q | take;
    end
    if (cmd_i.clr_en) begin
      valid_d = valid_q & ~match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Address slots carry no reset; valid bits guard them.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < INCOMING_SLOTS; i++) begin
      if (cmd_i.reg_en && !stat_o.hit && take[i]) begin
        addr_q[i] <= cmd_i.addr;
      end
    end
  end

endmodule

// File: src/link_setup_request_serializer_core.sv
// Link setup request serialiser: top level with sequencer and APB register.
//
// Channel  | Dir | Handshake             | Word
// input    | in  | in_valid_i/in_ready_o | in_word_t  (op, peer_address)
// output   | out | out_valid_o/out_ready_i| out_word_t (event_res, event_address, last)
// config   | in  | APB psel/penable      | halted at byte address 0
//
// One event at a time. A plain event passes decode and then an emit state per result
// word; an event that tries a launch also reads the queue head and checks it, with the
// check skipped when halted or the queue is empty. Cancel of a queued entry scans the
// queue memory with a read and a compare state per entry and closes the gap with a
// read and a write state per later entry, since the queue memory has one read port.
// Reset clears the counters, valid bits and outstanding slot at once.
// A stalled output holds the sequencer in its emit state.
`timescale 1ns / 1ps
module link_setup_request_serializer_core import lsrs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH    = QueueDepthDefault,
  parameter int unsigned INCOMING_SLOTS = IncomingSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [AddrW-1:0] a_q, a_d;
  res_e             res_q, res_d;
  logic [AddrW-1:0] ra_q, ra_d;
  logic             launch_q, launch_d;
  res_e             lres_q, lres_d;
  logic [AddrW-1:0] la_q, la_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IW-1:0]    head_q, head_d;
  logic [CW-1:0]    scan_q, scan_d;
  logic             ov_q, ov_d;
  logic             ok_q, ok_d;
  logic [AddrW-1:0] oa_q, oa_d;
  logic             halted_q;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  q_entry_t      mem_wdata, mem_rdata;
  logic [CW-1:0] rd_idx;
  inset_cmd_t    in_cmd;
  inset_stat_t   in_stat;
  logic          out_free;
  logic          cancel_kind;
  logic          head_ready;

  // Logical queue position to memory address.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [CW-1:0] idx);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(idx);
    if (sum >= SW'(QUEUE_DEPTH)) sum = sum - SW'(QUEUE_DEPTH);
    return sum[IW-1:0];
  endfunction

  lsrs_qmem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_qmem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  lsrs_inset #(.INCOMING_SLOTS(INCOMING_SLOTS)) u_inset (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (in_cmd),
    .stat_o(in_stat)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cancel_kind = (op_q == OP_CANCEL_NAME) ? KindName : KindConn;
  assign head_ready  = ((mem_rdata.kind == KindName) && in_stat.hit) ||
                       (in_stat.empty && !ov_q);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, halted_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      halted_q <= pwdata[0];
    end
  end

  always_comb begin
    rd_idx = '0;
    if (state_q == S_SCAN_RD) rd_idx = scan_q;
    if (state_q == S_SH_RD)   rd_idx = scan_q + CW'(1);
  end
  assign mem_raddr = phys(head_q, rd_idx);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (op_q)
          OP_ENQ_CONN, OP_ENQ_NAME, OP_CONN_DONE: state_d = S_HEAD_RD;
          OP_CONN_FAIL: state_d = (ov_q && ok_q == KindConn) ? S_HEAD_RD : S_EMIT1;
          OP_NAME_DONE: state_d = ov_q ? S_HEAD_RD : S_EMIT1;
          OP_CANCEL_CONN, OP_CANCEL_NAME: begin
            if (ov_q && ok_q == cancel_kind && oa_q == a_q) state_d = S_EMIT1;
            else state_d = S_SCAN_RD;
          end
          default: state_d = S_EMIT1;
        endcase
      end
      S_SCAN_RD:  state_d = (scan_q == count_q) ? S_EMIT1 : S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (mem_rdata.kind == cancel_kind && mem_rdata.addr == a_q) state_d = S_SH_RD;
        else state_d = S_SCAN_RD;
      end
      S_SH_RD: begin
        if (SW'(scan_q) + SW'(1) < SW'(count_q)) state_d = S_SH_WR;
        else state_d = S_EMIT1;
      end
      S_SH_WR:    state_d = S_SH_RD;
      S_HEAD_RD:  state_d = (halted_q || count_q == '0) ? S_EMIT1 : S_HEAD_CHK;
      S_HEAD_CHK: state_d = S_EMIT1;
      S_EMIT1: if (out_free) state_d = launch_q ? S_EMIT2 : S_IDLE;
      S_EMIT2: if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    op_d        = op_q;
    a_d         = a_q;
    res_d       = res_q;
    ra_d        = ra_q;
    launch_d    = launch_q;
    lres_d      = lres_q;
    la_d        = la_q;
    count_d     = count_q;
    head_d      = head_q;
    scan_d      = scan_q;
    ov_d        = ov_q;
    ok_d        = ok_q;
    oa_d        = oa_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = phys(head_q, count_q);
    mem_wdata   = '{kind: (op_q == OP_ENQ_NAME) ? KindName : KindConn, addr: a_q};
    in_cmd      = '{reg_en: 1'b0, clr_en: 1'b0, addr: a_q};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_e'(in_word_i.op);
          a_d      = in_word_i.peer_address;
          launch_d = 1'b0;
          scan_d   = '0;
        end
      end
      S_DECODE: begin
        res_d = RES_ACCEPTED;
        ra_d  = a_q;
        case (op_q)
          OP_ENQ_CONN, OP_ENQ_NAME: begin
            if (count_q == CW'(QUEUE_DEPTH)) begin
              res_d = RES_QUEUE_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CW'(1);
            end
          end
          OP_REG_IN: begin
            if (!in_stat.hit && in_stat.full) res_d = RES_SET_FULL;
            in_cmd.reg_en = !in_stat.full;
          end
          OP_CONN_DONE: begin
            in_cmd.clr_en = 1'b1;
            if (ov_q && ok_q == KindConn && oa_q == a_q) begin
              ov_d  = 1'b0;
              res_d = RES_DONE_OUT;
            end else begin
              res_d = in_stat.hit ? RES_DONE_IN : RES_DONE_UNKNOWN;
            end
          end
          OP_CONN_FAIL: begin
            ra_d = ov_q ? oa_q : '0;
            if (!ov_q)                 res_d = RES_NONE_OUT;
            else if (ok_q == KindName) res_d = RES_FAIL_NAME;
            else                       ov_d  = 1'b0;
          end
          OP_NAME_DONE: begin
            ra_d = ov_q ? oa_q : '0;
            if (!ov_q) begin
              res_d = RES_NONE_OUT;
            end else begin
              res_d = (ok_q == KindConn) ? RES_NAME_IN_CONN : RES_ACCEPTED;
              ov_d  = 1'b0;
            end
          end
          OP_CANCEL_CONN, OP_CANCEL_NAME: begin
            if (ov_q && ok_q == cancel_kind && oa_q == a_q) begin
              res_d = (cancel_kind == KindName) ? RES_CANCEL_FL_NAM : RES_CANCEL_FL_CON;
            end
          end
          default: ;
        endcase
      end
      S_SCAN_RD: if (scan_q == count_q) res_d = RES_NOT_FOUND;
      S_SCAN_CMP: begin
        if (mem_rdata.kind == cancel_kind && mem_rdata.addr == a_q) begin
          res_d = (cancel_kind == KindName) ? RES_CANCEL_Q_NAM : RES_CANCEL_Q_CON;
        end else begin
          scan_d = scan_q + CW'(1);
        end
      end
      S_SH_RD: begin
        if (!(SW'(scan_q) + SW'(1) < SW'(count_q))) count_d = count_q - CW'(1);
      end
      S_SH_WR: begin
        // Pull the later entry down over the gap.
        mem_we    = 1'b1;
        mem_waddr = phys(head_q, scan_q);
        mem_wdata = mem_rdata;
        scan_d    = scan_q + CW'(1);
      end
      S_HEAD_CHK: begin
        in_cmd.addr = mem_rdata.addr;
        if (head_ready) begin
          launch_d = 1'b1;
          lres_d   = (mem_rdata.kind == KindName) ? RES_LAUNCH_NAME : RES_LAUNCH_CONN;
          la_d     = mem_rdata.addr;
          ov_d     = 1'b1;
          ok_d     = mem_rdata.kind;
          oa_d     = mem_rdata.addr;
          count_d  = count_q - CW'(1);
          head_d   = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IW'(1);
        end
      end
      S_EMIT1: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{event_res: res_q, event_address: ra_q, last: !launch_q};
        end
      end
      S_EMIT2: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{event_res: lres_q, event_address: la_q, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      count_q     <= '0;
      head_q      <= '0;
      scan_q      <= '0;
      ov_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      count_q     <= count_d;
      head_q      <= head_d;
      scan_q      <= scan_d;
      ov_q        <= ov_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    a_q    <= a_d;
    res_q  <= res_d;
    ra_q   <= ra_d;
    lres_q <= lres_d;
    la_q   <= la_d;
    ok_q   <= ok_d;
    oa_q   <= oa_d;
    out_q  <= out_d;
  end

endmodule

// File: src/lsrs_checker.sv
// Port-level checks for the serialiser, bound to the top level.
`timescale 1ns / 1ps
module lsrs_checker import lsrs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input in_word_t            in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input out_word_t           out_word_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [ApbAddrW-1:0] paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);

  // One event at a time: no new word straight after one is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous event busy");

  // A word that is not last never waits while input is open.
  a_no_open_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(out_valid_o && !out_word_o.last))
    else $error("input open with a non-final word pending");

  // Launch words always close an event.
  a_launch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.event_res == RES_LAUNCH_CONN ||
                    out_word_o.event_res == RES_LAUNCH_NAME) |-> out_word_o.last)
    else $error("launch word not marked last");

  // Stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");

  // Register read back follows the last write.
  a_cfg_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr == '0 ##1 paddr == '0 && !(psel && penable && pwrite)
    |-> prdata[0] == $past(pwdata[0]))
    else $error("halted read back mismatch");

endmodule

bind link_setup_request_serializer_core lsrs_checker u_lsrs_checker (.*);
